// File: src/spq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

    localparam int DEPTH     = 64;
    localparam int LVLS      = 4;
    localparam int LVL_W     = $clog2(LVLS);
    localparam int PTR_W     = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int ADDR_W    = LVL_W + PTR_W;
    localparam int RAM_DEPTH = LVLS << PTR_W;
    localparam int TAG_W     = 16;
    localparam int ARR_W     = 16;
    localparam int PRI_W     = 3;
    localparam int OCC_W     = 7;
    localparam int RAM_W     = TAG_W + ARR_W;

    localparam logic FN_ADD    = 1'b0;
    localparam logic FN_REMOVE = 1'b1;

    localparam logic [PRI_W-1:0] PRI_MIN = PRI_W'(1);
    localparam logic [PRI_W-1:0] PRI_MAX = PRI_W'(LVLS);

    typedef enum logic [1:0] {
        ST_ADDED   = 2'd0,
        ST_REMOVED = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_FULL    = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_READ
    } t_state;

    typedef struct packed {
        logic             func;
        logic [PRI_W-1:0] priority_req;
        logic [TAG_W-1:0] tag;
    } t_in_item;

    typedef struct packed {
        logic [1:0]       status;
        logic [TAG_W-1:0] head_tag;
        logic [PRI_W-1:0] head_priority;
        logic [ARR_W-1:0] head_arrival;
        logic [OCC_W-1:0] occupancy;
    } t_out_item;

    typedef struct packed {
        logic latch;
        logic add;
        logic reject;
        logic empty;
        logic read;
        logic pop;
    } t_ctl_cmd;

    typedef struct packed {
        logic is_remove;
        logic full;
        logic empty;
    } t_ctl_sts;

endpackage

`default_nettype wire

// File: src/spq_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module spq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: src/spq_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module spq_ctrl
    import spq_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     start,
    input  wire t_ctl_sts i_sts,
    output t_ctl_cmd      o_cmd,
    output logic          busy
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_sts.is_remove && !i_sts.empty) begin
                    n_state = S_READ;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_READ: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        busy  = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                busy        = 1'b0;
                o_cmd.latch = start;
            end
            S_EXEC: begin
                if (i_sts.is_remove) begin
                    o_cmd.empty = i_sts.empty;
                    o_cmd.read  = !i_sts.empty;
                end else begin
                    o_cmd.reject = i_sts.full;
                    o_cmd.add    = !i_sts.full;
                end
            end
            S_READ: o_cmd.pop = 1'b1;
            default: busy = 1'b1;
        endcase
    end

endmodule

`default_nettype wire

// File: src/spq_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module spq_datapath
    import spq_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_in_item i_item,
    input  wire t_ctl_cmd i_cmd,
    output t_ctl_sts      o_sts,
    output t_out_item     o_result,
    output logic          o_result_valid
);

    t_in_item              r_item;
    logic [PTR_W-1:0]      r_head [LVLS];
    logic [PTR_W-1:0]      r_tail [LVLS];
    logic [CNT_W-1:0]      r_lvl_cnt [LVLS];
    logic [CNT_W-1:0]      r_count;
    logic [ARR_W-1:0]      r_arrival;
    logic [LVL_W-1:0]      r_sel;
    t_out_item             r_out;
    t_out_item             n_out;
    logic                  r_out_valid;

    logic [LVL_W-1:0]      add_idx;
    logic [LVL_W-1:0]      rm_idx;
    logic [RAM_W-1:0]      rd_data;
    logic [ADDR_W-1:0]     wr_addr;
    logic [ADDR_W-1:0]     rd_addr;

    // out-of-range levels fall to the least urgent class
    always_comb begin
        if (r_item.priority_req < PRI_MIN || r_item.priority_req > PRI_MAX) begin
            add_idx = LVL_W'(LVLS - 1);
        end else begin
            add_idx = LVL_W'(r_item.priority_req - PRI_MIN);
        end
    end

    always_comb begin
        rm_idx = LVL_W'(LVLS - 1);
        for (int k = LVLS - 1; k >= 0; k--) begin
            if (r_lvl_cnt[k] != '0) begin
                rm_idx = LVL_W'(k);
            end
        end
    end

    assign wr_addr = {add_idx, r_tail[add_idx]};
    assign rd_addr = {rm_idx, r_head[rm_idx]};

    assign o_sts.is_remove = (r_item.func == FN_REMOVE);
    assign o_sts.full      = (r_count >= CNT_W'(DEPTH));
    assign o_sts.empty     = (r_count == '0);

    spq_ram #(
        .WIDTH (RAM_W),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.add),
        .i_wr_addr (wr_addr),
        .i_wr_data ({r_item.tag, r_arrival}),
        .i_rd_en   (i_cmd.read),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_comb begin
        n_out           = '0;
        n_out.occupancy = OCC_W'(r_count);
        if (i_cmd.add) begin
            n_out.status    = ST_ADDED;
            n_out.occupancy = OCC_W'(r_count + CNT_W'(1));
        end else if (i_cmd.reject) begin
            n_out.status = ST_FULL;
        end else if (i_cmd.empty) begin
            n_out.status = ST_EMPTY;
        end else if (i_cmd.pop) begin
            n_out.status        = ST_REMOVED;
            n_out.head_tag      = rd_data[RAM_W-1:ARR_W];
            n_out.head_arrival  = rd_data[ARR_W-1:0];
            n_out.head_priority = PRI_W'(r_sel) + PRI_MIN;
            n_out.occupancy     = OCC_W'(r_count - CNT_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_item <= i_item;
        end
        if (i_cmd.read) begin
            r_sel <= rm_idx;
        end
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_arrival   <= ARR_W'(1);
            r_out_valid <= 1'b0;
            for (int k = 0; k < LVLS; k++) begin
                r_head[k]    <= '0;
                r_tail[k]    <= '0;
                r_lvl_cnt[k] <= '0;
            end
        end else begin
            r_out_valid <= i_cmd.add | i_cmd.reject | i_cmd.empty | i_cmd.pop;
            if (i_cmd.add) begin
                r_tail[add_idx]    <= r_tail[add_idx] + PTR_W'(1);
                r_lvl_cnt[add_idx] <= r_lvl_cnt[add_idx] + CNT_W'(1);
                r_count            <= r_count + CNT_W'(1);
                r_arrival          <= r_arrival + ARR_W'(1);
            end else if (i_cmd.pop) begin
                r_head[r_sel]    <= r_head[r_sel] + PTR_W'(1);
                r_lvl_cnt[r_sel] <= r_lvl_cnt[r_sel] - CNT_W'(1);
                r_count          <= r_count - CNT_W'(1);
            end
        end
    end

    assign o_result       = r_out;
    assign o_result_valid = r_out_valid;

endmodule

`default_nettype wire

// File: src/stable_priority_queue_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Stable priority queue: up to DEPTH entries ordered by level (1 most urgent),
// first in first out among entries of equal level.
// Input channel: an item (add or remove) is taken at a clock edge where start
// is high and busy is low. Levels outside 1..4 are treated as level 4.
// Output channel: each item gives exactly one result, shown on o_result for
// one cycle with o_result_valid high. The receiver cannot stall this channel.
// Flow: busy stays high from acceptance until the item is done, so a new item
// is taken only after the previous one. Add, rejected add and remove-when-empty
// are decided in the EXEC state and their result is registered. A remove that
// finds an entry then goes through READ for the registered entry memory read.
// Entries live in one memory split into one circular region per level; the
// head comes from the most urgent non-empty region.
// Reset (synchronous, active low) empties the queue and sets the arrival
// number to one; memory contents are not cleared and need no clearing pass.

module stable_priority_queue_unit
    import spq_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     start,
    input  wire t_in_item i_item,
    output logic          busy,
    output logic          o_result_valid,
    output t_out_item     o_result
);

    t_ctl_cmd cmd;
    t_ctl_sts sts;

    spq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .busy    (busy)
    );

    spq_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_item         (i_item),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_result       (o_result),
        .o_result_valid (o_result_valid)
    );

endmodule

`default_nettype wire

// File: test/stable_priority_queue_unit_tb.sv
`timescale 1ns / 1ps

module stable_priority_queue_unit_tb;
    import spq_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 10;
    localparam int RANDOM_ITEMS = 240;

    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic [PRI_W-1:0] level;
        logic [ARR_W-1:0] arrival;
    } t_entry;

    logic      i_clk;
    logic      i_rst_n;
    logic      start;
    logic      busy;
    logic      o_result_valid;
    t_in_item  i_item;
    t_out_item o_result;

    t_entry           held_entries[$];
    logic [ARR_W-1:0] next_arrival;
    t_out_item        expected_results[$];
    int               failures;
    int               stalled_cycles;
    int               idle_pct;
    int               n_added;
    int               n_removed;
    int               n_empty;
    int               n_full;

    stable_priority_queue_unit DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .i_item         (i_item),
        .busy           (busy),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // queue model: ordered by level, arrival order among equal levels
    function automatic t_out_item predict_result(t_in_item item);
        t_out_item        res;
        t_entry           e;
        int               pos;
        logic [PRI_W-1:0] lvl;
        res = '0;
        if (item.func == FN_ADD) begin
            if (held_entries.size() >= DEPTH) begin
                res.status = ST_FULL;
                n_full++;
            end else begin
                lvl = (item.priority_req < PRI_MIN || item.priority_req > PRI_MAX) ?
                      PRI_MAX : item.priority_req;
                pos = held_entries.size();
                for (int k = 0; k < held_entries.size(); k++) begin
                    if (held_entries[k].level > lvl) begin
                        pos = k;
                        break;
                    end
                end
                e.tag     = item.tag;
                e.level   = lvl;
                e.arrival = next_arrival;
                held_entries.insert(pos, e);
                next_arrival++;
                res.status = ST_ADDED;
                n_added++;
            end
        end else if (held_entries.size() == 0) begin
            res.status = ST_EMPTY;
            n_empty++;
        end else begin
            e = held_entries.pop_front();
            res.status        = ST_REMOVED;
            res.head_tag      = e.tag;
            res.head_priority = e.level;
            res.head_arrival  = e.arrival;
            n_removed++;
        end
        res.occupancy = OCC_W'(held_entries.size());
        return res;
    endfunction

    task automatic send_item(input logic func, input logic [PRI_W-1:0] pri,
                             input logic [TAG_W-1:0] tag);
        t_in_item item;
        item.func         = func;
        item.priority_req = pri;
        item.tag          = tag;
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= item;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        expected_results.push_back(predict_result(item));
    endtask

    function automatic logic [PRI_W-1:0] random_level();
        return ($urandom_range(99) < 85) ? PRI_W'($urandom_range(1, 4)) :
                                           PRI_W'($urandom_range(0, 7));
    endfunction

    task automatic check_field(input string name, input int unsigned exp_val,
                               input int unsigned act_val);
        if (exp_val != act_val) begin
            $error("%s: expected %0d, got %0d", name, exp_val, act_val);
            failures++;
        end
    endtask

    always @(posedge i_clk) begin : check_results
        t_out_item exp_res;
        if (i_rst_n && o_result_valid) begin
            if (expected_results.size() == 0) begin
                $error("status: expected no result, got %0d", o_result.status);
                failures++;
            end else begin
                exp_res = expected_results.pop_front();
                check_field("status", exp_res.status, o_result.status);
                check_field("head_tag", exp_res.head_tag, o_result.head_tag);
                check_field("head_priority", exp_res.head_priority, o_result.head_priority);
                check_field("head_arrival", exp_res.head_arrival, o_result.head_arrival);
                check_field("occupancy", exp_res.occupancy, o_result.occupancy);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_result_valid) begin
            stalled_cycles <= 0;
        end else if (stalled_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            stalled_cycles <= stalled_cycles + 1;
        end
    end

    // every level code, tag extremes, remove on empty
    task automatic test_directed();
        idle_pct = 34;
        send_item(FN_REMOVE, 3'd0, 16'h0000);
        send_item(FN_ADD, 3'd4, 16'h0001);
        send_item(FN_ADD, 3'd1, 16'hFFFF);
        send_item(FN_ADD, 3'd2, 16'h1234);
        send_item(FN_ADD, 3'd1, 16'h0000);
        send_item(FN_ADD, 3'd3, 16'hA5A5);
        send_item(FN_ADD, 3'd0, 16'h5A5A);
        send_item(FN_ADD, 3'd5, 16'h8001);
        send_item(FN_ADD, 3'd7, 16'h7FFE);
        send_item(FN_ADD, 3'd6, 16'hC3C3);
        send_item(FN_ADD, 3'd4, 16'h3C3C);
        repeat (10) send_item(FN_REMOVE, 3'd7, 16'hFFFF);
        send_item(FN_REMOVE, 3'd1, 16'hBEEF);
    endtask

    // fill to capacity, rejected adds, then drain past empty
    task automatic test_full_queue();
        idle_pct = 34;
        repeat (DEPTH) send_item(FN_ADD, random_level(), TAG_W'($urandom));
        repeat (3) send_item(FN_ADD, random_level(), TAG_W'($urandom));
        send_item(FN_REMOVE, 3'd0, 16'h0000);
        send_item(FN_ADD, 3'd1, 16'hFFFF);
        send_item(FN_ADD, 3'd1, 16'h0000);
        repeat (DEPTH + 2) send_item(FN_REMOVE, random_level(), TAG_W'($urandom));
    endtask

    task automatic test_random();
        int sent;
        int phase_len;
        int add_pct;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            phase_len = $urandom_range(20, 60);
            case ($urandom_range(3))
                0: add_pct = 20;
                1: add_pct = 50;
                2: add_pct = 80;
                default: add_pct = 95;
            endcase
            idle_pct = (sent >= 80 && sent < 180) ? 0 : 34;
            repeat (phase_len) begin
                send_item(($urandom_range(99) < add_pct) ? FN_ADD : FN_REMOVE,
                          random_level(), TAG_W'($urandom));
                sent++;
            end
        end
    endtask

    initial begin
        i_rst_n         = 1'b0;
        start           = 1'b0;
        i_item          = '0;
        failures        = 0;
        stalled_cycles  = 0;
        idle_pct        = 34;
        next_arrival    = ARR_W'(1);
        n_added         = 0;
        n_removed       = 0;
        n_empty         = 0;
        n_full          = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_full_queue();
        test_random();
        start <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("covered %0d adds, %0d removes, %0d removes on empty, %0d rejected adds",
                 n_added, n_removed, n_empty, n_full);
        if (failures == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
